/* rtl/core/b64d_pkg.sv */
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, register indexes and character tables of the Base64 stream decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

  localparam int CfgAddrWidth = 2;

  typedef enum logic [CfgAddrWidth-1:0] {
    REG_URL_ALPHABET    = 2'd0,
    REG_CHECK_PADDING   = 2'd1,
    REG_SKIP_WHITESPACE = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] PAD_CHAR  = 8'h3D;
  localparam logic [5:0] SEXTET_62 = 6'h3E;
  localparam logic [5:0] SEXTET_63 = 6'h3F;

  // Work handed from the front to the back: up to three bytes, sent first to
  // last from bytes[0], optionally followed by the status result.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nbytes;
    logic            has_status;
    logic            err;
  } b64d_job_t;

  // Returns {hit, sextet} for one character code.
  function automatic logic [6:0] sextet_lookup(input logic [15:0] c, input logic url);
    logic [7:0] b;
    logic [7:0] d;
    logic [6:0] res;
    b   = c[7:0];
    d   = 8'h00;
    res = 7'h00;
    if (c[15:8] == 8'h00) begin
      if (b >= 8'h41 && b <= 8'h5A) begin
        d   = b - 8'h41;
        res = {1'b1, d[5:0]};
      end else if (b >= 8'h61 && b <= 8'h7A) begin
        d   = b - 8'h61 + 8'd26;
        res = {1'b1, d[5:0]};
      end else if (b >= 8'h30 && b <= 8'h39) begin
        d   = b - 8'h30 + 8'd52;
        res = {1'b1, d[5:0]};
      end else if (url) begin
        if (b == 8'h2D) res = {1'b1, SEXTET_62};
        else if (b == 8'h5F) res = {1'b1, SEXTET_63};
      end else begin
        if (b == 8'h2B) res = {1'b1, SEXTET_62};
        else if (b == 8'h2F) res = {1'b1, SEXTET_63};
      end
    end
    return res;
  endfunction

  function automatic logic is_space(input logic [15:0] c);
    return c == 16'h0020 || c == 16'h0009 || c == 16'h000A ||
           c == 16'h000D || c == 16'h000C;
  endfunction

endpackage

/* rtl/core/b64d_front.sv */
// ----------------------------------------------------------------------------
// b64d_front
// Classifies each character, keeps the per-string decode state and turns
// every item that causes results into one job for the back end.
// ----------------------------------------------------------------------------
module b64d_front import b64d_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CfgAddrWidth-1:0] cfg_addr,
  input  logic                    cfg_wdata,
  input  logic                    accept,
  input  logic [15:0]             character,
  input  logic                    char_present,
  input  logic                    end_of_text,
  output logic                    push,
  output b64d_job_t               job
);

  logic        url_alphabet;
  logic        check_padding;
  logic        skip_whitespace;

  logic [17:0] acc;
  logic [1:0]  cnt;
  logic [1:0]  pad;
  logic        any_data;
  logic        err_seen;

  logic [17:0] acc_next;
  logic [1:0]  cnt_next;
  logic [1:0]  pad_next;
  logic        any_next;
  logic        err_next;
  logic [6:0]  lookup;
  logic [23:0] word;
  logic        status_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      url_alphabet    <= 1'b0;
      check_padding   <= 1'b0;
      skip_whitespace <= 1'b0;
    end else if (cfg_wr_en) begin
      if (cfg_addr == REG_URL_ALPHABET)    url_alphabet    <= cfg_wdata;
      if (cfg_addr == REG_CHECK_PADDING)   check_padding   <= cfg_wdata;
      if (cfg_addr == REG_SKIP_WHITESPACE) skip_whitespace <= cfg_wdata;
    end
  end

  assign lookup = sextet_lookup(character, url_alphabet);
  assign word   = {acc, lookup[5:0]};

  always_comb begin
    acc_next   = acc;
    cnt_next   = cnt;
    pad_next   = pad;
    any_next   = any_data;
    err_next   = err_seen;
    job        = '0;
    status_err = 1'b0;

    if (char_present && !err_seen) begin
      if (character == {8'h00, PAD_CHAR}) begin
        if (pad != 2'd3) pad_next = pad + 2'd1;
        if (check_padding && pad_next == 2'd3) err_next = 1'b1;
      end else if (lookup[6]) begin
        if (pad != 2'd0) begin
          err_next = 1'b1;
        end else begin
          any_next = 1'b1;
          if (cnt == 2'd3) begin
            job.bytes[0] = word[23:16];
            job.bytes[1] = word[15:8];
            job.bytes[2] = word[7:0];
            job.nbytes   = 2'd3;
            acc_next     = '0;
            cnt_next     = 2'd0;
          end else begin
            acc_next = word[17:0];
            cnt_next = cnt + 2'd1;
          end
        end
      end else if (!skip_whitespace || !is_space(character)) begin
        err_next = 1'b1;
      end
    end

    if (end_of_text) begin
      // A completed group leaves no sextets behind, so the tail bytes below
      // never collide with the three bytes of a group.
      status_err = err_next;
      if (!err_next) begin
        if (!any_next) begin
          status_err = pad_next != 2'd0;
        end else if (check_padding && pad_next != 2'd0 && (cnt_next + pad_next) != 2'd0) begin
          status_err = 1'b1;
        end else if (cnt_next == 2'd1) begin
          status_err = 1'b1;
        end else if (cnt_next == 2'd2) begin
          job.bytes[0] = acc_next[11:4];
          job.nbytes   = 2'd1;
        end else if (cnt_next == 2'd3) begin
          job.bytes[0] = acc_next[17:10];
          job.bytes[1] = acc_next[9:2];
          job.nbytes   = 2'd2;
        end
      end
      job.has_status = 1'b1;
      job.err        = status_err;
      acc_next = '0;
      cnt_next = 2'd0;
      pad_next = 2'd0;
      any_next = 1'b0;
      err_next = 1'b0;
    end
  end

  assign push = accept && (job.has_status || job.nbytes != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      cnt      <= 2'd0;
      pad      <= 2'd0;
      any_data <= 1'b0;
      err_seen <= 1'b0;
    end else if (accept) begin
      acc      <= acc_next;
      cnt      <= cnt_next;
      pad      <= pad_next;
      any_data <= any_next;
      err_seen <= err_next;
    end
  end

endmodule

/* rtl/core/b64d_queue.sv */
// ----------------------------------------------------------------------------
// b64d_queue
// Small first-in first-out queue of jobs between the front and the back.
// ----------------------------------------------------------------------------
module b64d_queue import b64d_pkg::*; #(
  parameter int Depth = 4
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  b64d_job_t push_job,
  output logic      full,
  input  logic      pop,
  output logic      not_empty,
  output b64d_job_t head
);

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  b64d_job_t       mem [Depth];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;

  assign full      = count == (AW+1)'(Depth);
  assign not_empty = count != '0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == AW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == AW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop)      count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

/* rtl/core/b64d_back.sv */
// ----------------------------------------------------------------------------
// b64d_back
// Takes jobs from the queue and sends their results one per cycle, while the
// output is ready, through an output register.
// ----------------------------------------------------------------------------
module b64d_back import b64d_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_not_empty,
  input  b64d_job_t q_head,
  output logic      pop,
  output logic      m_tvalid,
  input  logic      m_tready,
  output logic [7:0] m_tdata,
  output logic [1:0] m_tuser,
  output logic      m_tlast
);

  b64d_job_t  cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic [2:0] total;
  logic       cur_last;
  logic       load_out;
  logic [7:0] sel_byte;
  logic       sel_status;

  assign total      = {1'b0, cur.nbytes} + {2'b00, cur.has_status};
  assign cur_last   = ({1'b0, idx} + 3'd1) == total;
  assign load_out   = cur_valid && (!m_tvalid || m_tready);
  assign pop        = q_not_empty && (!cur_valid || (load_out && cur_last));
  assign sel_status = {1'b0, idx} >= {1'b0, cur.nbytes};

  always_comb begin
    case (idx)
      2'd0:    sel_byte = cur.bytes[0];
      2'd1:    sel_byte = cur.bytes[1];
      2'd2:    sel_byte = cur.bytes[2];
      default: sel_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (load_out) begin
      if (cur_last) cur_valid <= 1'b0;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= sel_status ? 8'h00 : sel_byte;
      m_tuser <= {sel_status & cur.err, sel_status};
      m_tlast <= cur_last;
    end
  end

endmodule

/* rtl/core/base64_stream_decoder.sv */
// ----------------------------------------------------------------------------
// base64_stream_decoder
// Base64 text decoder, standard or URL-safe alphabet, one character an item.
// ----------------------------------------------------------------------------
// A character item is taken every cycle while the job queue has room. Each
// item that yields results becomes one job of up to three bytes plus an
// optional status, so a character that completes a group yields three
// results and an end item up to four. The queue of QueueDepth jobs absorbs
// that burst; the output side, through its output register, sends one result
// per cycle while the output is ready. The status result (tuser[0] high)
// closes each string; when its error flag (tuser[1]) is set, the bytes of
// that string must be discarded. The user must write configuration only
// while the block is idle; the block itself does not enforce it.
module base64_stream_decoder import b64d_pkg::*; #(
  parameter int QueueDepth = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CfgAddrWidth-1:0] cfg_addr,
  input  logic                    cfg_wdata,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [15:0]             s_tdata,   // [15:0] character
  input  logic                    s_tuser,   // [0] char_present
  input  logic                    s_tlast,   // end_of_text
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [7:0]              m_tdata,   // [7:0] data_byte
  output logic [1:0]              m_tuser,   // [0] is_status, [1] decode_error
  output logic                    m_tlast    // last
);

  logic      accept;
  logic      push;
  b64d_job_t job;
  logic      q_full;
  logic      q_not_empty;
  logic      pop;
  b64d_job_t q_head;

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  b64d_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .accept       (accept),
    .character    (s_tdata),
    .char_present (s_tuser),
    .end_of_text  (s_tlast),
    .push         (push),
    .job          (job)
  );

  b64d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (job),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  b64d_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast)
  );

endmodule

/* verif/b64d_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// b64d_checker
// Watches both streams of the Base64 decoder, predicts every result from the
// accepted characters and the register writes, and compares the results in
// order. The failure count and the number of results still owed go to the top.
// ----------------------------------------------------------------------------
module b64d_checker import b64d_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_wr_en,
  input  logic [CfgAddrWidth-1:0] cfg_addr,
  input  logic                    cfg_wdata,
  input  logic                    s_tvalid,
  input  logic                    s_tready,
  input  logic [15:0]             s_tdata,   // [15:0] character
  input  logic                    s_tuser,   // [0] char_present
  input  logic                    s_tlast,   // end_of_text
  input  logic                    m_tvalid,
  input  logic                    m_tready,
  input  logic [7:0]              m_tdata,   // [7:0] data_byte
  input  logic [1:0]              m_tuser,   // [0] is_status, [1] decode_error
  input  logic                    m_tlast,   // last
  output int                      failures,
  output int                      pending
);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_status;
    logic       decode_error;
    logic       last_flag;
  } b64_result_t;

  b64_result_t decoded_fifo[$];
  int          mismatches;

  logic        url_mode;
  logic        pad_strict;
  logic        ws_skip;

  logic [17:0] group_bits;
  logic [1:0]  group_count;
  logic [1:0]  pads_seen;
  logic        saw_data;
  logic        string_failed;

  function automatic b64_result_t make_result(input logic [7:0] b, input logic st,
                                              input logic er);
    b64_result_t r;
    r.data_byte    = b;
    r.is_status    = st;
    r.decode_error = er;
    r.last_flag    = 1'b0;
    return r;
  endfunction

  function automatic logic char_to_sextet(input logic [15:0] c, input logic url,
                                          output logic [5:0] v);
    v = 6'd0;
    if (c >= 16'h0041 && c <= 16'h005A) begin
      v = 6'(c - 16'h0041);
      return 1'b1;
    end
    if (c >= 16'h0061 && c <= 16'h007A) begin
      v = 6'(c - 16'h0061 + 16'd26);
      return 1'b1;
    end
    if (c >= 16'h0030 && c <= 16'h0039) begin
      v = 6'(c - 16'h0030 + 16'd52);
      return 1'b1;
    end
    if (c == (url ? 16'h002D : 16'h002B)) begin
      v = SEXTET_62;
      return 1'b1;
    end
    if (c == (url ? 16'h005F : 16'h002F)) begin
      v = SEXTET_63;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic decode_character(input logic [15:0] c, input logic present,
                                  input logic eot);
    b64_result_t burst[$];
    logic [5:0]  v;
    logic [23:0] w;
    logic        err;
    logic        is_ws;
    is_ws = c == 16'h0020 || c == 16'h0009 || c == 16'h000A ||
            c == 16'h000D || c == 16'h000C;
    if (present && !string_failed) begin
      if (c == {8'h00, PAD_CHAR}) begin
        if (pads_seen != 2'd3) pads_seen = pads_seen + 2'd1;
        if (pad_strict && pads_seen == 2'd3) string_failed = 1'b1;
      end else if (char_to_sextet(c, url_mode, v)) begin
        if (pads_seen != 2'd0) begin
          string_failed = 1'b1;
        end else begin
          saw_data = 1'b1;
          if (group_count == 2'd3) begin
            w = {group_bits, v};
            burst.push_back(make_result(w[23:16], 1'b0, 1'b0));
            burst.push_back(make_result(w[15:8], 1'b0, 1'b0));
            burst.push_back(make_result(w[7:0], 1'b0, 1'b0));
            group_bits  = '0;
            group_count = 2'd0;
          end else begin
            group_bits  = {group_bits[11:0], v};
            group_count = group_count + 2'd1;
          end
        end
      end else if (!ws_skip || !is_ws) begin
        string_failed = 1'b1;
      end
    end
    if (eot) begin
      err = string_failed;
      if (!err) begin
        if (!saw_data) begin
          err = pads_seen != 2'd0;
        end else if (pad_strict && pads_seen != 2'd0 &&
                     2'(group_count + pads_seen) != 2'd0) begin
          err = 1'b1;
        end else if (group_count == 2'd1) begin
          err = 1'b1;
        end else if (group_count == 2'd2) begin
          burst.push_back(make_result(group_bits[11:4], 1'b0, 1'b0));
        end else if (group_count == 2'd3) begin
          burst.push_back(make_result(group_bits[17:10], 1'b0, 1'b0));
          burst.push_back(make_result(group_bits[9:2], 1'b0, 1'b0));
        end
      end
      burst.push_back(make_result(8'h00, 1'b1, err));
      group_bits    = '0;
      group_count   = 2'd0;
      pads_seen     = 2'd0;
      saw_data      = 1'b0;
      string_failed = 1'b0;
    end
    if (burst.size() > 0) burst[burst.size() - 1].last_flag = 1'b1;
    foreach (burst[i]) decoded_fifo.push_back(burst[i]);
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    b64_result_t want;
    if (rst) begin
      decoded_fifo.delete();
      mismatches    = 0;
      url_mode      = 1'b0;
      pad_strict    = 1'b0;
      ws_skip       = 1'b0;
      group_bits    = '0;
      group_count   = 2'd0;
      pads_seen     = 2'd0;
      saw_data      = 1'b0;
      string_failed = 1'b0;
    end else begin
      // Results are checked before this edge's character is predicted, so a
      // result can never be matched against its own input.
      if (m_tvalid && m_tready) begin
        if (decoded_fifo.size() == 0) begin
          $error("result with nothing expected: data_byte 0x%0h, tuser 0x%0h, last %0b",
                 m_tdata, m_tuser, m_tlast);
          mismatches++;
        end else begin
          want = decoded_fifo.pop_front();
          compare_field("data_byte", want.data_byte, m_tdata);
          compare_field("is_status", want.is_status, m_tuser[0]);
          compare_field("decode_error", want.decode_error, m_tuser[1]);
          compare_field("last", want.last_flag, m_tlast);
        end
      end
      if (cfg_wr_en) begin
        case (cfg_addr)
          REG_URL_ALPHABET:    url_mode   = cfg_wdata;
          REG_CHECK_PADDING:   pad_strict = cfg_wdata;
          REG_SKIP_WHITESPACE: ws_skip    = cfg_wdata;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) decode_character(s_tdata, s_tuser, s_tlast);
    end
    failures <= mismatches;
    pending  <= decoded_fifo.size();
  end

endmodule

/* verif/tb_base64_stream_decoder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_base64_stream_decoder
// Drives the Base64 decoder with directed strings and then with random ones,
// mostly valid encodings with some damaged, under several register settings
// and with random gaps on the input and stalls on the output. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_base64_stream_decoder;
  import b64d_pkg::*;

  localparam int TimeoutCycles = 200000;
  localparam int SettleCycles  = 12;

  logic                    clk;
  logic                    rst;
  logic                    cfg_wr_en;
  logic [CfgAddrWidth-1:0] cfg_addr;
  logic                    cfg_wdata;
  logic                    s_tvalid;
  logic                    s_tready;
  logic [15:0]             s_tdata;   // [15:0] character
  logic                    s_tuser;   // [0] char_present
  logic                    s_tlast;   // end_of_text
  logic                    m_tvalid;
  logic                    m_tready;
  logic [7:0]              m_tdata;   // [7:0] data_byte
  logic [1:0]              m_tuser;   // [0] is_status, [1] decode_error
  logic                    m_tlast;   // last

  int   failures;
  int   pending;
  int   chars_sent;
  int   burst_left;
  logic cur_url;
  int   rx_mode;
  int   rx_timer;

  base64_stream_decoder DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  b64d_checker decode_check (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .failures  (failures),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(TimeoutCycles * 12);
    $display("FAILURE");
    $finish;
  end

  // The output side switches among always ready, mostly ready, mostly stalled
  // and a regular on/off pattern, each held for a random stretch.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_mode  <= 0;
      rx_timer <= 0;
    end else begin
      if (rx_timer == 0) begin
        rx_mode  <= $urandom_range(0, 3);
        rx_timer <= $urandom_range(8, 80);
      end else begin
        rx_timer <= rx_timer - 1;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 3) != 0;
        2: m_tready <= $urandom_range(0, 3) == 0;
        default: m_tready <= rx_timer[2];
      endcase
    end
  end

  function automatic logic [15:0] sextet_char(input logic [5:0] v, input logic url);
    if (v < 6'd26) return 16'h0041 + v;
    if (v < 6'd52) return 16'h0061 + v - 16'd26;
    if (v < 6'd62) return 16'h0030 + v - 16'd52;
    if (v == SEXTET_62) return url ? 16'h002D : 16'h002B;
    return url ? 16'h005F : 16'h002F;
  endfunction

  function automatic logic [15:0] space_char();
    case ($urandom_range(0, 4))
      0: return 16'h0020;
      1: return 16'h0009;
      2: return 16'h000A;
      3: return 16'h000D;
      default: return 16'h000C;
    endcase
  endfunction

  function automatic logic [15:0] noise_char();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 127));
      2: return {8'($urandom_range(1, 255)), 8'($urandom_range(0, 127))};
      default: return space_char();
    endcase
  endfunction

  // Sends one item; the sender runs in bursts separated by random gaps.
  task automatic send_item(input logic [15:0] ch, input logic present, input logic eot);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 10);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tuser  <= present;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
    if (present || eot) chars_sent++;
  endtask

  task automatic send_text(input string txt, input logic close);
    for (int i = 0; i < txt.len(); i++)
      send_item({8'h00, txt[i]}, 1'b1, close && i == txt.len() - 1);
  endtask

  // Holds the input until every expected result is out, then lets the block
  // finish any character that produced nothing.
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_config(input logic url, input logic pad, input logic ws);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= REG_URL_ALPHABET;
    cfg_wdata <= url;
    @(posedge clk);
    cfg_addr  <= REG_CHECK_PADDING;
    cfg_wdata <= pad;
    @(posedge clk);
    cfg_addr  <= REG_SKIP_WHITESPACE;
    cfg_wdata <= ws;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cur_url = url;
  endtask

  // Encodes random bytes with the current alphabet, then often damages the text:
  // whitespace, stray characters, bad padding, or a dropped or extra character.
  task automatic send_random_string();
    logic [7:0]  payload[$];
    logic [15:0] text[$];
    logic [23:0] w;
    logic        use_pad;
    logic        bare_close;
    int          nbytes;
    int          rem;
    int          k;
    nbytes  = $urandom_range(0, 9);
    use_pad = $urandom_range(0, 2) != 0;
    repeat (nbytes) payload.push_back(8'($urandom));
    for (k = 0; k < nbytes; k += 3) begin
      rem = nbytes - k;
      // Unused low bits of a short group get random filler half the time.
      w = $urandom_range(0, 1) ? 24'($urandom) : 24'h0;
      w[23:16] = payload[k];
      if (rem > 1) w[15:8] = payload[k + 1];
      if (rem > 2) w[7:0] = payload[k + 2];
      text.push_back(sextet_char(w[23:18], cur_url));
      text.push_back(sextet_char(w[17:12], cur_url));
      if (rem > 1) text.push_back(sextet_char(w[11:6], cur_url));
      else if (use_pad) text.push_back({8'h00, PAD_CHAR});
      if (rem > 2) text.push_back(sextet_char(w[5:0], cur_url));
      else if (use_pad) text.push_back({8'h00, PAD_CHAR});
    end
    case ($urandom_range(0, 9))
      6: repeat ($urandom_range(1, 3))
           text.insert($urandom_range(0, text.size()), space_char());
      7: text.insert($urandom_range(0, text.size()), noise_char());
      8: begin
        case ($urandom_range(0, 3))
          0: repeat ($urandom_range(1, 4)) text.push_back({8'h00, PAD_CHAR});
          1: if (text.size() > 0) void'(text.pop_back());
          2: text.insert($urandom_range(0, text.size()), {8'h00, PAD_CHAR});
          default: text.push_back(sextet_char(6'($urandom), cur_url));
        endcase
      end
      9: begin
        case ($urandom_range(0, 3))
          0: text.insert($urandom_range(0, text.size()), 16'h002B);
          1: text.insert($urandom_range(0, text.size()), 16'h002F);
          2: text.insert($urandom_range(0, text.size()), 16'h002D);
          default: text.insert($urandom_range(0, text.size()), 16'h005F);
        endcase
      end
      default: ;
    endcase
    bare_close = text.size() == 0 || $urandom_range(0, 4) == 0;
    for (k = 0; k < text.size(); k++) begin
      if ($urandom_range(0, 15) == 0) send_item(16'($urandom), 1'b0, 1'b0);
      send_item(text[k], 1'b1, !bare_close && k == text.size() - 1);
    end
    if (bare_close) send_item(16'($urandom), 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    logic [2:0] setting;
    rst        <= 1'b1;
    cfg_wr_en  <= 1'b0;
    cfg_addr   <= REG_URL_ALPHABET;
    cfg_wdata  <= 1'b0;
    s_tvalid   <= 1'b0;
    s_tdata    <= 16'h0000;
    s_tuser    <= 1'b0;
    s_tlast    <= 1'b0;
    chars_sent = 0;
    burst_left = 0;
    cur_url    = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_config(1'b0, 1'b0, 1'b0);
    send_item(16'h0000, 1'b0, 1'b1);      // empty string
    send_text("TWFu", 1'b1);              // full group closed on its last character
    send_text("+/9z", 1'b1);
    send_text("QQ==", 1'b1);
    send_text("Zm8", 1'b1);               // unpadded partial group
    send_text("A", 1'b1);                 // single leftover sextet
    send_text("=", 1'b1);                 // pads with no data
    send_item(16'h0141, 1'b1, 1'b1);      // low byte is a letter, high byte is not zero
    send_text("Q=A", 1'b1);               // data after a pad
    send_item(16'hFFFF, 1'b0, 1'b0);      // ignored, produces nothing
    wait_idle();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: setting = 3'b000;
        1: setting = 3'b111;
        2: setting = 3'b101;
        3: setting = 3'b010;
        default: setting = 3'($urandom);
      endcase
      set_config(setting[0], setting[1], setting[2]);
      while (chars_sent < 25 + 50 * (phase + 1)) send_random_string();
      wait_idle();
    end

    if (failures == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
